@@ hw/rtl/zssd_pkg.sv @@
// Package for the zero-suppressed sequence decoder.
// Holds the result kind codes, the result record type and shared constants.
// No dependencies.
package zssd_pkg;

	typedef enum logic [1:0] {
		KIND_RECORD    = 2'd0,
		KIND_NO_HEADER = 2'd1,
		KIND_ORDER     = 2'd2,
		KIND_RANGE     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  pad_row;
		logic [7:0]  pad_number;
		logic [9:0]  start_bin;
		logic [10:0] run_length;
		logic [19:0] adc_offset;
		logic [8:0]  seq_index;
		logic        last;
	} res_t;

	localparam logic [7:0]         PAD_END       = 8'hFF;
	localparam logic signed [11:0] LAST_BIN_INIT = -12'sd2;
	localparam logic [10:0]        LEN_MAX       = 11'h7FF;

	function automatic res_t make_res(kind_t k, logic [6:0] row, logic [7:0] pad,
			logic [9:0] start, logic [10:0] len, logic [19:0] off, logic [8:0] idx);
		res_t r;
		r.kind       = k;
		r.pad_row    = row;
		r.pad_number = pad;
		r.start_bin  = start;
		r.run_length = len;
		r.adc_offset = off;
		r.seq_index  = idx;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

@@ hw/rtl/zero_suppressed_sequence_decoder_core.sv @@
// Zero-suppressed sequence decoder, top level.
// Input register, single-pass decode logic and a two-entry result pair register.
// Depends on zssd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one descriptor word per transaction,
//   with bank_start on the first word of a bank and bank_end on the last.
//   Output channel (out_valid / out_stall) carries result records and error
//   results; each input word yields zero, one or two results, the last one of a
//   word flagged by last.
// Path: a word is registered in the input register, then decoded into the result
//   pair register, from which its first result is presented on the output.
// Throughput: one word per cycle while each word yields at most one result and
//   the receiver does not stall; a word with two results holds back the next word
//   while the single output port drains the result pair register.
// Stall: when the receiver stalls, the held result and its fields stay put; at most one
//   more word is taken into the input register, then in_stall rises.
// Reset: arst_n clears all decode state and empties both registers; decoding
//   starts as if a bank had just begun.
module zero_suppressed_sequence_decoder_core #(
	parameter int NUM_ROWS = 64,
	parameter int MAX_PADS = 254
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] word,
	input  logic        bank_start,
	input  logic        bank_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [6:0]  pad_row,
	output logic [7:0]  pad_number,
	output logic [9:0]  start_bin,
	output logic [10:0] run_length,
	output logic [19:0] adc_offset,
	output logic [8:0]  seq_index,
	output logic        last
);
	import zssd_pkg::*;

	localparam logic [6:0] ROW_MAX = 7'(NUM_ROWS);
	localparam logic [7:0] PAD_MAX = 8'(MAX_PADS);

	// input register
	logic        valid_s1;
	logic [15:0] word_s1;
	logic        bank_start_s1;
	logic        bank_end_s1;

	// decode state
	logic               header_seen_q;
	logic               stopped_q;
	logic [6:0]         cur_row_q;
	logic [7:0]         cur_pad_q;
	logic signed [11:0] last_bin_q;
	logic [9:0]         prev_start_q;
	logic               pend_valid_q;
	logic [9:0]         pend_start_q;
	logic [10:0]        pend_len_q;
	logic [19:0]        pend_off_q;
	logic [19:0]        adc_cnt_q;
	logic [8:0]         seq_cnt_q;

	// result pair register
	logic [1:0] res_cnt_q;
	res_t       res0_q;
	res_t       res1_q;

	// decode outputs
	logic               hs_c;
	logic               st_c;
	logic [6:0]         row_c;
	logic [7:0]         pad_c;
	logic signed [11:0] lb_c;
	logic [9:0]         ps_c;
	logic               pv_c;
	logic [9:0]         pst_c;
	logic [10:0]        pl_c;
	logic [19:0]        po_c;
	logic [19:0]        ac_c;
	logic [8:0]         sc_c;
	logic [1:0]         n_c;
	res_t               res_c [2];

	logic pop;
	logic can_load;
	logic adv_s1;

	assign pop      = (res_cnt_q != 2'd0) && !out_stall;
	assign can_load = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && pop);
	assign adv_s1   = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_comb begin
		logic [9:0]         start;
		logic [4:0]         len;
		logic [6:0]         hrow;
		logic [7:0]         hpad;
		logic [11:0]        len_sum;
		logic signed [12:0] reach;
		logic               new_run;

		start   = word_s1[15:6];
		len     = word_s1[4:0];
		hrow    = word_s1[14:8];
		hpad    = word_s1[7:0];
		len_sum = '0;
		reach   = '0;
		new_run = 1'b0;
		n_c      = '0;
		res_c[0] = '0;
		res_c[1] = '0;

		hs_c  = header_seen_q;
		st_c  = stopped_q;
		row_c = cur_row_q;
		pad_c = cur_pad_q;
		lb_c  = last_bin_q;
		ps_c  = prev_start_q;
		pv_c  = pend_valid_q;
		pst_c = pend_start_q;
		pl_c  = pend_len_q;
		po_c  = pend_off_q;
		ac_c  = adc_cnt_q;
		sc_c  = seq_cnt_q;
		if (bank_start_s1) begin
			hs_c  = 1'b0;
			st_c  = 1'b0;
			row_c = '0;
			pad_c = '0;
			lb_c  = LAST_BIN_INIT;
			ps_c  = '0;
			pv_c  = 1'b0;
			pst_c = '0;
			pl_c  = '0;
			po_c  = '0;
			ac_c  = '0;
			sc_c  = '0;
		end

		if (!st_c) begin
			if (word_s1[15]) begin
				if (pv_c) begin
					res_c[n_c[0]] = make_res(KIND_RECORD, row_c, pad_c, pst_c, pl_c, po_c,
						sc_c - 9'd1);
					n_c  = n_c + 2'd1;
					pv_c = 1'b0;
				end
				if (hpad == PAD_END) begin
					st_c = 1'b1;
				end else if (hrow == 7'd0 || hrow > ROW_MAX || hpad == 8'd0 ||
						hpad > PAD_MAX) begin
					res_c[n_c[0]] = make_res(KIND_RANGE, hrow, hpad, '0, '0, '0, '0);
					n_c  = n_c + 2'd1;
					st_c = 1'b1;
				end else begin
					row_c = hrow;
					pad_c = hpad;
					hs_c  = 1'b1;
					ps_c  = '0;
					lb_c  = LAST_BIN_INIT;
					sc_c  = '0;
				end
			end else if (!hs_c) begin
				res_c[n_c[0]] = make_res(KIND_NO_HEADER, row_c, pad_c, '0, '0, '0, '0);
				n_c  = n_c + 2'd1;
				st_c = 1'b1;
				pv_c = 1'b0;
			end else if (pad_c == 8'd0 || pad_c > PAD_MAX) begin
				if (pv_c) begin
					res_c[n_c[0]] = make_res(KIND_RECORD, row_c, pad_c, pst_c, pl_c, po_c,
						sc_c - 9'd1);
					n_c = n_c + 2'd1;
				end
				res_c[n_c[0]] = make_res(KIND_RANGE, row_c, pad_c, '0, '0, '0, '0);
				n_c  = n_c + 2'd1;
				st_c = 1'b1;
				pv_c = 1'b0;
			end else if (start < ps_c) begin
				if (pv_c) begin
					res_c[n_c[0]] = make_res(KIND_RECORD, row_c, pad_c, pst_c, pl_c, po_c,
						sc_c - 9'd1);
					n_c = n_c + 2'd1;
				end
				res_c[n_c[0]] = make_res(KIND_ORDER, row_c, pad_c, start, '0, '0, '0);
				n_c  = n_c + 2'd1;
				st_c = 1'b1;
				pv_c = 1'b0;
			end else begin
				reach   = 13'(lb_c) + 13'sd1;
				new_run = !pv_c || ($signed({3'b000, start}) > reach);
				if (new_run) begin
					if (pv_c) begin
						res_c[n_c[0]] = make_res(KIND_RECORD, row_c, pad_c, pst_c, pl_c, po_c,
							sc_c - 9'd1);
						n_c = n_c + 2'd1;
					end
					pv_c  = 1'b1;
					pst_c = start;
					pl_c  = 11'(len);
					po_c  = ac_c;
					sc_c  = sc_c + 9'd1;
				end else begin
					len_sum = {1'b0, pl_c} + 12'(len);
					pl_c    = len_sum[11] ? LEN_MAX : len_sum[10:0];
				end
				ac_c = ac_c + 20'(len);
				lb_c = $signed({2'b00, start} + 12'(len) - 12'd1);
				ps_c = start;
				if (word_s1[5]) begin
					res_c[n_c[0]] = make_res(KIND_RECORD, row_c, pad_c, pst_c, pl_c, po_c,
						sc_c - 9'd1);
					n_c   = n_c + 2'd1;
					pv_c  = 1'b0;
					pad_c = pad_c + 8'd1;
					sc_c  = '0;
					lb_c  = LAST_BIN_INIT;
					ps_c  = '0;
				end
			end
		end

		if (bank_end_s1) begin
			if (pv_c) begin
				res_c[n_c[0]] = make_res(KIND_RECORD, row_c, pad_c, pst_c, pl_c, po_c,
					sc_c - 9'd1);
				n_c = n_c + 2'd1;
			end
			st_c = 1'b1;
			pv_c = 1'b0;
		end

		if (n_c == 2'd2) begin
			res_c[1].last = 1'b1;
		end else if (n_c == 2'd1) begin
			res_c[0].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1       <= word;
			bank_start_s1 <= bank_start;
			bank_end_s1   <= bank_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q <= 1'b0;
			stopped_q     <= 1'b0;
			cur_row_q     <= '0;
			cur_pad_q     <= '0;
			last_bin_q    <= LAST_BIN_INIT;
			prev_start_q  <= '0;
			pend_valid_q  <= 1'b0;
			pend_start_q  <= '0;
			pend_len_q    <= '0;
			pend_off_q    <= '0;
			adc_cnt_q     <= '0;
			seq_cnt_q     <= '0;
		end else if (adv_s1) begin
			header_seen_q <= hs_c;
			stopped_q     <= st_c;
			cur_row_q     <= row_c;
			cur_pad_q     <= pad_c;
			last_bin_q    <= lb_c;
			prev_start_q  <= ps_c;
			pend_valid_q  <= pv_c;
			pend_start_q  <= pst_c;
			pend_len_q    <= pl_c;
			pend_off_q    <= po_c;
			adc_cnt_q     <= ac_c;
			seq_cnt_q     <= sc_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (adv_s1) begin
			res_cnt_q <= n_c;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res0_q <= res_c[0];
			res1_q <= res_c[1];
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign out_valid  = (res_cnt_q != 2'd0);
	assign kind       = res0_q.kind;
	assign pad_row    = res0_q.pad_row;
	assign pad_number = res0_q.pad_number;
	assign start_bin  = res0_q.start_bin;
	assign run_length = res0_q.run_length;
	assign adc_offset = res0_q.adc_offset;
	assign seq_index  = res0_q.seq_index;
	assign last       = res0_q.last;

endmodule

@@ hw/rtl/zssd_checker.sv @@
// Port-level checker for the zero-suppressed sequence decoder.
// Bound to zero_suppressed_sequence_decoder_core; depends on zssd_pkg.
module zssd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [6:0]  pad_row,
	input logic [7:0]  pad_number,
	input logic [9:0]  start_bin,
	input logic [10:0] run_length,
	input logic [19:0] adc_offset,
	input logic [8:0]  seq_index,
	input logic        last
);
	import zssd_pkg::*;

	// held transaction does not change under stall
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(pad_row) &&
			$stable(pad_number) && $stable(start_bin) && $stable(run_length) &&
			$stable(adc_offset) && $stable(seq_index) && $stable(last))
		else $error("output transaction changed under stall");

	// an error ends the word's results
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_RECORD |-> last)
		else $error("error result not flagged last");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_RECORD |->
			run_length == 11'd0 && seq_index == 9'd0 && adc_offset == 20'd0)
		else $error("error result carries record fields");

	// records only follow a valid header
	a_rec_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_RECORD |-> pad_row != 7'd0 && pad_number != 8'd0)
		else $error("record with zero row or pad");

endmodule

bind zero_suppressed_sequence_decoder_core zssd_checker u_zssd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.pad_row    (pad_row),
	.pad_number (pad_number),
	.start_bin  (start_bin),
	.run_length (run_length),
	.adc_offset (adc_offset),
	.seq_index  (seq_index),
	.last       (last)
);
